[sv/ffha_pkg.sv]
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int HEAP_BYTES_DEF    = 1024;
  localparam int GRANULE_BYTES_DEF = 16;
  localparam int FIELD_W           = 10;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic rd_g;
    logic rd_zero;
    logic rd_nxt;
    logic adv;
    logic wr_split;
    logic wr_grant_all;
    logic wr_grant_need;
    logic res_grant;
    logic wr_free;
    logic res_freed;
    logic head_latch;
    logic merge_wr;
    logic merge_adv;
    logic clr_nxt;
    logic out_load;
  } ffha_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_free;
    logic foff_ok;
    logic fit;
    logic split;
    logic walk_end;
    logic hdr;
    logic step_end;
    logic mergeable;
    logic out_busy;
  } ffha_sts_t;

endpackage

[sv/first_fit_heap_allocator.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_op, in_request_bytes, in_free_offset
// out_      output     out_valid/out_ready  out_data_offset, out_ok
//
// Alloc: each block visited on the first-fit walk is read in S_A_RD and
// checked in S_A_CHK, the block table having a registered read.
// Free: lookup, then a merge walk that joins adjacent free blocks.
// After reset the table is swept, one granule per cycle, with in_ready
// low. A result waits in the output register; the next transaction is
// taken once it has been loaded there.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES    = HEAP_BYTES_DEF,
  parameter int GRANULE_BYTES = GRANULE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [FIELD_W-1:0] in_request_bytes,
  input  logic [FIELD_W-1:0] in_free_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] out_data_offset,
  output logic               out_ok
);

  ffha_cmd_t cmd;
  ffha_sts_t sts;

  ffha_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .GRANULE_BYTES(GRANULE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_request_bytes(in_request_bytes),
    .in_free_offset  (in_free_offset),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_offset (out_data_offset),
    .out_ok          (out_ok),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

[sv/ffha_ram.sv]
`timescale 1ns / 1ps
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/ffha_ctrl.sv]
`timescale 1ns / 1ps
module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ffha_sts_t sts,
  output ffha_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_WG,
    S_F_RD,
    S_F_CHK,
    S_M_RD0,
    S_M_HEAD,
    S_M_STEP,
    S_M_NXT,
    S_M_CLR,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!sts.in_free) begin
            state_nxt = S_A_RD;
          end else if (sts.foff_ok) begin
            state_nxt = S_F_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_A_RD: begin
        cmd.rd_g  = 1'b1;
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        if (sts.fit) begin
          cmd.res_grant = 1'b1;
          if (sts.split) begin
            cmd.wr_split = 1'b1;
            state_nxt    = S_A_WG;
          end else begin
            cmd.wr_grant_all = 1'b1;
            state_nxt        = S_DONE;
          end
        end else if (sts.walk_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = S_A_RD;
        end
      end
      S_A_WG: begin
        cmd.wr_grant_need = 1'b1;
        state_nxt         = S_DONE;
      end
      S_F_RD: begin
        cmd.rd_g  = 1'b1;
        state_nxt = S_F_CHK;
      end
      S_F_CHK: begin
        if (sts.hdr) begin
          cmd.wr_free   = 1'b1;
          cmd.res_freed = 1'b1;
          state_nxt     = S_M_RD0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_M_RD0: begin
        cmd.rd_zero = 1'b1;
        state_nxt   = S_M_HEAD;
      end
      S_M_HEAD: begin
        cmd.head_latch = 1'b1;
        state_nxt      = S_M_STEP;
      end
      S_M_STEP: begin
        if (sts.step_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_nxt = 1'b1;
          state_nxt  = S_M_NXT;
        end
      end
      S_M_NXT: begin
        if (sts.mergeable) begin
          cmd.merge_wr = 1'b1;
          state_nxt    = S_M_CLR;
        end else begin
          cmd.merge_adv = 1'b1;
          state_nxt     = S_M_STEP;
        end
      end
      S_M_CLR: begin
        cmd.clr_nxt = 1'b1;
        state_nxt   = S_M_STEP;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/ffha_dp.sv]
`timescale 1ns / 1ps
module ffha_dp
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES    = HEAP_BYTES_DEF,
  parameter int GRANULE_BYTES = GRANULE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_op,
  input  logic [FIELD_W-1:0] in_request_bytes,
  input  logic [FIELD_W-1:0] in_free_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] out_data_offset,
  output logic               out_ok,
  input  ffha_cmd_t          cmd,
  output ffha_sts_t          sts
);

  localparam int NG     = HEAP_BYTES / GRANULE_BYTES;
  localparam int GW     = $clog2(NG);
  localparam int EW     = GW + 2;
  localparam int NEED_W = $clog2(((1 << FIELD_W) - 1 + GRANULE_BYTES - 1) / GRANULE_BYTES + 1);
  localparam int CW     = (NEED_W > GW) ? NEED_W : GW;

  logic [GW-1:0]      g_r;
  logic [GW-1:0]      nxt_r;
  logic [NEED_W-1:0]  need_r;
  logic               cur_busy_r;
  logic [GW-1:0]      cur_cnt_r;
  logic               res_ok_r;
  logic [FIELD_W-1:0] res_off_r;
  logic               out_valid_r;
  logic [FIELD_W-1:0] out_data_offset_r;
  logic               out_ok_r;

  logic               ram_we;
  logic [GW-1:0]      ram_waddr;
  logic [EW-1:0]      ram_wdata;
  logic               ram_re;
  logic [GW-1:0]      ram_raddr;
  logic [EW-1:0]      ram_rdata;

  logic               rd_hdr;
  logic               rd_busy;
  logic [GW-1:0]      rd_cnt;

  logic [FIELD_W:0]   req_round;
  logic [NEED_W-1:0]  need_in;
  logic [FIELD_W-1:0] free_g;
  logic [GW:0]        walk_nxt;
  logic [GW:0]        step_nxt;
  logic [CW:0]        rest;
  logic [CW+1:0]      nh;
  logic [GW-1:0]      merged;
  logic [EW-1:0]      init_entry;

  assign {rd_hdr, rd_busy, rd_cnt} = ram_rdata;

  assign req_round = {1'b0, in_request_bytes} + (FIELD_W+1)'(GRANULE_BYTES - 1);
  assign need_in   = NEED_W'(req_round / GRANULE_BYTES);
  assign free_g    = FIELD_W'(in_free_offset / GRANULE_BYTES) - FIELD_W'(1);

  assign walk_nxt = {1'b0, g_r} + (GW+1)'(1) + {1'b0, rd_cnt};
  assign step_nxt = {1'b0, g_r} + (GW+1)'(1) + {1'b0, cur_cnt_r};
  assign rest     = (CW+1)'(rd_cnt) - (CW+1)'(need_r);
  assign nh       = (CW+2)'(g_r) + (CW+2)'(1) + (CW+2)'(need_r);
  assign merged   = cur_cnt_r + rd_cnt + GW'(1);

  assign init_entry = (g_r == '0) ? {1'b1, 1'b0, GW'(NG - 1)} : '0;

  always_comb begin
    sts           = '0;
    sts.clr_last  = (g_r == GW'(NG - 1));
    sts.in_free   = (in_op == OP_FREE);
    sts.foff_ok   = ({1'b0, in_free_offset} >= (FIELD_W+1)'(GRANULE_BYTES))
                 && ((in_free_offset % GRANULE_BYTES) == '0)
                 && (32'(free_g) < 32'(NG));
    sts.fit       = !rd_busy && ((CW+1)'(rd_cnt) >= (CW+1)'(need_r));
    sts.split     = (rest >= (CW+1)'(2)) && (nh < (CW+2)'(NG));
    sts.walk_end  = (walk_nxt >= (GW+1)'(NG));
    sts.hdr       = rd_hdr;
    sts.step_end  = (step_nxt >= (GW+1)'(NG));
    sts.mergeable = !cur_busy_r && !rd_busy;
    sts.out_busy  = out_valid_r && !out_ready;
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = g_r;
    if (cmd.rd_g) begin
      ram_re = 1'b1;
    end else if (cmd.rd_zero) begin
      ram_re    = 1'b1;
      ram_raddr = '0;
    end else if (cmd.rd_nxt) begin
      ram_re    = 1'b1;
      ram_raddr = GW'(step_nxt);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = g_r;
    ram_wdata = '0;
    if (cmd.clr_wr) begin
      ram_we    = 1'b1;
      ram_wdata = init_entry;
    end else if (cmd.wr_split) begin
      ram_we    = 1'b1;
      ram_waddr = GW'(nh);
      ram_wdata = {1'b1, 1'b0, GW'(rest - (CW+1)'(1))};
    end else if (cmd.wr_grant_all) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b1, 1'b1, rd_cnt};
    end else if (cmd.wr_grant_need) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b1, 1'b1, GW'(need_r)};
    end else if (cmd.wr_free) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b1, 1'b0, rd_cnt};
    end else if (cmd.merge_wr) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b1, 1'b0, merged};
    end else if (cmd.clr_nxt) begin
      ram_we    = 1'b1;
      ram_waddr = nxt_r;
    end
  end

  ffha_ram #(
    .WIDTH(EW),
    .DEPTH(NG)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r <= '0;
    end else if (cmd.clr_wr) begin
      g_r <= sts.clr_last ? '0 : g_r + GW'(1);
    end else if (cmd.load) begin
      g_r <= sts.in_free ? GW'(free_g) : '0;
    end else if (cmd.adv) begin
      g_r <= GW'(walk_nxt);
    end else if (cmd.rd_zero) begin
      g_r <= '0;
    end else if (cmd.merge_adv) begin
      g_r <= nxt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      need_r    <= need_in;
      res_ok_r  <= 1'b0;
      res_off_r <= '0;
    end
    if (cmd.res_grant) begin
      res_ok_r  <= 1'b1;
      res_off_r <= FIELD_W'((32'(g_r) + 32'd1) * 32'(GRANULE_BYTES));
    end
    if (cmd.res_freed) begin
      res_ok_r <= 1'b1;
    end
    if (cmd.rd_nxt) begin
      nxt_r <= GW'(step_nxt);
    end
    if (cmd.head_latch || cmd.merge_adv) begin
      cur_busy_r <= rd_busy;
      cur_cnt_r  <= rd_cnt;
    end else if (cmd.merge_wr) begin
      cur_cnt_r <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_offset_r <= res_off_r;
      out_ok_r          <= res_ok_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_offset = out_data_offset_r;
  assign out_ok          = out_ok_r;

endmodule

[tb/first_fit_heap_allocator_tb.sv]
`timescale 1ns / 1ps
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int GRANULES     = HEAP_BYTES_DEF / GRANULE_BYTES_DEF;
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int SCRIPT_ROWS  = 25;

  typedef logic [FIELD_W-1:0] field_t;

  typedef struct packed {
    field_t offset;
    logic   ok;
  } grant_t;

  typedef struct packed {
    logic   op;
    field_t req;
    field_t foff;
    logic   fixed;
    grant_t want;
  } script_row_t;

  // fixed rows: after reset, oversize, misaligned or zero offset
  localparam script_row_t HEAP_SCRIPT [SCRIPT_ROWS] = '{
    '{OP_ALLOC, 10'd0,    10'd1023, 1'b1, '{10'd16, 1'b1}},
    '{OP_ALLOC, 10'd1009, 10'd0,    1'b1, '{10'd0,  1'b0}},
    '{OP_ALLOC, 10'd1023, 10'd1023, 1'b1, '{10'd0,  1'b0}},
    '{OP_FREE,  10'd1023, 10'd8,    1'b1, '{10'd0,  1'b0}},
    '{OP_FREE,  10'd0,    10'd0,    1'b1, '{10'd0,  1'b0}},
    '{OP_ALLOC, 10'd1,    10'd0,    1'b0, '0},
    '{OP_ALLOC, 10'd16,   10'd0,    1'b0, '0},
    '{OP_ALLOC, 10'd17,   10'd0,    1'b0, '0},
    '{OP_FREE,  10'd0,    10'd32,   1'b0, '0},
    '{OP_FREE,  10'd0,    10'd32,   1'b0, '0},
    '{OP_FREE,  10'd0,    10'd64,   1'b0, '0},
    '{OP_ALLOC, 10'd1008, 10'd0,    1'b0, '0},
    '{OP_FREE,  10'd0,    10'd16,   1'b0, '0},
    '{OP_FREE,  10'd0,    10'd96,   1'b0, '0},
    '{OP_ALLOC, 10'd1008, 10'd0,    1'b0, '0},
    '{OP_ALLOC, 10'd0,    10'd0,    1'b0, '0},
    '{OP_FREE,  10'd0,    10'd16,   1'b0, '0},
    '{OP_ALLOC, 10'd992,  10'd0,    1'b0, '0},
    '{OP_FREE,  10'd0,    10'd16,   1'b0, '0},
    '{OP_ALLOC, 10'd976,  10'd0,    1'b0, '0},
    '{OP_ALLOC, 10'd16,   10'd0,    1'b0, '0},
    '{OP_FREE,  10'd0,    10'd1008, 1'b0, '0},
    '{OP_FREE,  10'd0,    10'd1023, 1'b1, '{10'd0,  1'b0}},
    '{OP_FREE,  10'd0,    10'd1008, 1'b0, '0},
    '{OP_FREE,  10'd0,    10'd16,   1'b0, '0}
  };

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  logic   in_op;
  field_t in_request_bytes;
  field_t in_free_offset;
  logic   out_valid;
  logic   out_ready;
  field_t out_data_offset;
  logic   out_ok;

  logic        heap_hdr  [GRANULES];
  logic        heap_busy [GRANULES];
  int unsigned heap_len  [GRANULES];

  grant_t grants_due[$];
  field_t busy_offsets[$];
  int     error_count = 0;
  int     cycle_count = 0;
  bit     tx_burst = 1'b0;
  bit     rx_burst = 1'b0;

  first_fit_heap_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_request_bytes (in_request_bytes),
    .in_free_offset   (in_free_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_offset  (out_data_offset),
    .out_ok           (out_ok)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void heap_reset();
    for (int i = 0; i < GRANULES; i++) begin
      heap_hdr[i]  = 1'b0;
      heap_busy[i] = 1'b0;
      heap_len[i]  = 0;
    end
    heap_hdr[0] = 1'b1;
    heap_len[0] = GRANULES - 1;
  endfunction

  function automatic grant_t heap_apply(input logic op, input field_t req, input field_t foff);
    grant_t      r;
    int unsigned need;
    int unsigned g;
    int unsigned have;
    int unsigned rest;
    int unsigned nh;
    bit          done;
    r = '0;
    if (op == OP_ALLOC) begin
      need = (int'(req) + GRANULE_BYTES_DEF - 1) / GRANULE_BYTES_DEF;
      g = 0;
      while (g < GRANULES && !r.ok) begin
        have = heap_len[g];
        if (!heap_busy[g] && have >= need) begin
          rest = have - need;
          // split only if the remainder keeps a data granule past its header
          if (rest >= 2) begin
            nh = g + 1 + need;
            if (nh < GRANULES) begin
              heap_hdr[nh]  = 1'b1;
              heap_busy[nh] = 1'b0;
              heap_len[nh]  = rest - 1;
              heap_len[g]   = need;
            end
          end
          heap_busy[g] = 1'b1;
          r.offset = field_t'((g + 1) * GRANULE_BYTES_DEF);
          r.ok = 1'b1;
        end else begin
          g = g + 1 + have;
        end
      end
    end else if (foff >= GRANULE_BYTES_DEF && foff % GRANULE_BYTES_DEF == 0) begin
      g = foff / GRANULE_BYTES_DEF - 1;
      if (g < GRANULES && heap_hdr[g]) begin
        heap_busy[g] = 1'b0;
        g = 0;
        done = 1'b0;
        while (g < GRANULES && !done) begin
          nh = g + 1 + heap_len[g];
          if (nh >= GRANULES) begin
            done = 1'b1;
          end else if (!heap_busy[g] && !heap_busy[nh]) begin
            heap_len[g]  = heap_len[g] + heap_len[nh] + 1;
            heap_hdr[nh]  = 1'b0;
            heap_busy[nh] = 1'b0;
            heap_len[nh]  = 0;
          end else begin
            g = nh;
          end
        end
        r.ok = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  task automatic send_item(input logic op, input field_t req, input field_t foff,
                           input logic fixed, input grant_t fixed_want);
    int     gap;
    grant_t pred;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_request_bytes <= req;
    in_free_offset   <= foff;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = heap_apply(op, req, foff);
    grants_due.push_back(fixed ? fixed_want : pred);
    if (pred.ok && op == OP_ALLOC) begin
      busy_offsets.push_back(pred.offset);
    end else if (pred.ok) begin
      for (int i = busy_offsets.size() - 1; i >= 0; i--) begin
        if (busy_offsets[i] == foff) busy_offsets.delete(i);
      end
    end
  endtask

  initial begin
    int     pick;
    logic   op;
    field_t req;
    field_t foff;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_op            <= OP_ALLOC;
    in_request_bytes <= '0;
    in_free_offset   <= '0;
    heap_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < SCRIPT_ROWS; n++) begin
      send_item(HEAP_SCRIPT[n].op, HEAP_SCRIPT[n].req, HEAP_SCRIPT[n].foff,
                HEAP_SCRIPT[n].fixed, HEAP_SCRIPT[n].want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      // hold off until the output side has drained
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        while (grants_due.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      req  = ($urandom_range(0, 9) == 0) ? field_t'($urandom_range(0, 1023))
                                         : field_t'($urandom_range(0, 96));
      foff = field_t'($urandom_range(0, 1023));
      if (pick < 45 || (pick < 85 && busy_offsets.size() == 0)) begin
        op = OP_ALLOC;
      end else begin
        op = OP_FREE;
        if (pick < 85) begin
          foff = busy_offsets[$urandom_range(0, busy_offsets.size() - 1)];
        end else if (pick < 93) begin
          foff = field_t'($urandom_range(0, GRANULES - 1) * GRANULE_BYTES_DEF);
        end
      end
      send_item(op, req, foff, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (grants_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int     gap;
    int     seen;
    grant_t want;
    seen = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (seen % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      seen++;
      if (grants_due.size() == 0) begin
        report_mismatch("transaction with nothing due, offset", out_data_offset, 0);
      end else begin
        want = grants_due.pop_front();
        if (out_data_offset !== want.offset)
          report_mismatch("data_offset", out_data_offset, want.offset);
        if (out_ok !== want.ok)
          report_mismatch("ok", out_ok, want.ok);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
